[src/pks_pkg.sv]
package pks_pkg;

  // Input mode codes.
  localparam logic [1:0] ModeTick = 2'd0;
  localparam logic [1:0] ModeOn   = 2'd1;
  localparam logic [1:0] ModeOff  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgHeldMethod   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgHasControl   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgHasStatus    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgActiveLevel  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgStatusOnLvl  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgPulseTicks   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgTimeoutTicks = 3'd6;

  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned TicksW      = 16;
  localparam int unsigned CountBitsDefault = 16;
  localparam logic [TicksW-1:0] DefaultTimeout = 16'd10000;

  // One input beat.
  typedef struct packed {
    logic [1:0] mode;
    logic       status_pin;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic key_level;
    logic busy_res;
    logic done_res;
    logic success;
    logic modem_on;
  } out_item_t;

  // Current configuration.
  typedef struct packed {
    logic              held_method;
    logic              has_control_pin;
    logic              has_status_pin;
    logic              active_level;
    logic              status_on_level;
    logic [TicksW-1:0] pulse_ticks;
    logic [TicksW-1:0] timeout_ticks;
  } cfg_t;

endpackage

[src/modem_power_key_sequencer_top.sv]
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_ready_o  | in_data_i  (in_item_t)
// out     | output    | out_valid_o / out_ready_i| out_data_o (out_item_t)
// cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// Each beat passes an input register, then the combinational sequencer logic
// that loads the result register. One beat is accepted per cycle while the
// result register is empty or being drained; the sequencer state advances as
// the result register loads. Reset returns the key to level one and the
// sequencer to idle. When the result register is full and not taken, the input
// register holds one more beat and then in_ready_o drops.
module modem_power_key_sequencer_top
  import pks_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_vld_q;
  out_item_t res, out_q;
  logic      out_vld_q;
  logic      advance, process;

  pks_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The result register can load when empty or being drained.
  assign advance    = !out_vld_q || out_ready_i;
  assign process    = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  pks_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (process),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // A completed request always leaves the sequencer idle.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res)
    else $error("done result still reports busy");

  // Success is only reported together with completion.
  a_success_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.success |-> out_data_o.done_res)
    else $error("success without done");

  // Input stalls only when the result register is full and stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

endmodule

[src/pks_cfg_regs.sv]
module pks_cfg_regs
  import pks_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write index into one register.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHeldMethod:   cfg_d.held_method     = cfg_data_i[0];
        CfgHasControl:   cfg_d.has_control_pin = cfg_data_i[0];
        CfgHasStatus:    cfg_d.has_status_pin  = cfg_data_i[0];
        CfgActiveLevel:  cfg_d.active_level    = cfg_data_i[0];
        CfgStatusOnLvl:  cfg_d.status_on_level = cfg_data_i[0];
        CfgPulseTicks:   cfg_d.pulse_ticks     = cfg_data_i[TicksW-1:0];
        CfgTimeoutTicks: cfg_d.timeout_ticks   = cfg_data_i[TicksW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{held_method: 1'b0, has_control_pin: 1'b0, has_status_pin: 1'b0,
                 active_level: 1'b0, status_on_level: 1'b0,
                 pulse_ticks: '0, timeout_ticks: DefaultTimeout};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/pks_core.sv]
module pks_core
  import pks_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  typedef enum logic [1:0] {
    PhIdle,
    PhPulseOff,
    PhPulseOn,
    PhWait
  } phase_e;

  localparam int unsigned CmpW = (COUNT_BITS > TicksW) ? COUNT_BITS : TicksW;

  phase_e                phase_q, phase_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  key_q, key_d;
  logic                  want_on_q, want_on_d;

  logic                  is_on, status_hit, is_tick, is_req, req_on;
  logic                  done, ok;
  logic [COUNT_BITS-1:0] count_inc;
  logic [CmpW-1:0]       count_ext, pulse_ext, timeout_ext;
  logic                  inactive;

  assign inactive = ~cfg_i.active_level;
  assign is_on    = cfg_i.has_status_pin ? (item_i.status_pin == cfg_i.status_on_level)
                                         : 1'b1;
  assign is_tick  = (item_i.mode == ModeTick);
  assign is_req   = (item_i.mode == ModeOn) || (item_i.mode == ModeOff);
  assign req_on   = (item_i.mode == ModeOn);

  // Saturating tick counter, compared after the increment.
  assign count_inc   = (&count_q) ? count_q : count_q + 1'b1;
  assign count_ext   = CmpW'(count_inc);
  assign pulse_ext   = CmpW'(cfg_i.pulse_ticks);
  assign timeout_ext = CmpW'(cfg_i.timeout_ticks);

  // Next-state logic for one beat.
  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    key_d      = key_q;
    want_on_d  = want_on_q;
    done       = 1'b0;
    ok         = 1'b0;
    status_hit = (is_on == want_on_q);
    unique case (phase_q)
      PhIdle: begin
        if (is_req) begin
          want_on_d  = req_on;
          status_hit = (is_on == req_on);
          if (!cfg_i.has_control_pin) begin
            done = 1'b1;
            ok   = 1'b1;
          end else if (cfg_i.held_method) begin
            key_d = req_on ? cfg_i.active_level : inactive;
            if (!cfg_i.has_status_pin || status_hit) begin
              done = 1'b1;
              ok   = 1'b1;
            end else begin
              phase_d = PhWait;
              count_d = '0;
            end
          end else if (cfg_i.has_status_pin && status_hit) begin
            done = 1'b1;
            ok   = 1'b1;
          end else begin
            key_d   = inactive;
            phase_d = PhPulseOff;
            count_d = '0;
          end
        end
      end
      PhPulseOff: begin
        if (is_tick) begin
          count_d = count_inc;
          if (count_ext >= pulse_ext) begin
            key_d   = cfg_i.active_level;
            phase_d = PhPulseOn;
            count_d = '0;
          end
        end
      end
      PhPulseOn: begin
        if (is_tick) begin
          count_d = count_inc;
          if (count_ext >= pulse_ext) begin
            key_d   = inactive;
            count_d = '0;
            if (!cfg_i.has_status_pin) begin
              phase_d = PhIdle;
              done    = 1'b1;
              ok      = 1'b1;
            end else begin
              phase_d = PhWait;
            end
          end
        end
      end
      PhWait: begin
        if (status_hit) begin
          phase_d = PhIdle;
          done    = 1'b1;
          ok      = 1'b1;
        end else if (is_tick) begin
          count_d = count_inc;
          if (count_ext >= timeout_ext) begin
            phase_d = PhIdle;
            done    = 1'b1;
          end
        end
      end
      default: phase_d = PhIdle;
    endcase
  end

  // Result of this beat, taken from the updated state.
  always_comb begin
    res_o.key_level = key_d;
    res_o.busy_res  = (phase_d != PhIdle);
    res_o.done_res  = done;
    res_o.success   = ok;
    res_o.modem_on  = is_on;
  end

  // Sequencer state, advanced once per processed beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      count_q   <= '0;
      key_q     <= 1'b1;
      want_on_q <= 1'b0;
    end else if (en_i) begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      key_q     <= key_d;
      want_on_q <= want_on_d;
    end
  end

endmodule

[dv/modem_power_key_sequencer_top_tb.sv]
`timescale 1ns / 1ps

module modem_power_key_sequencer_top_tb
  import pks_pkg::*;
;

  // Mode 3 is neither a tick nor a request.
  localparam logic [1:0] ModeSpare = 2'd3;

  localparam int unsigned NumPhases  = 12;
  localparam int unsigned PhaseBeats = 150;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned WatchLimit = 2000;

  // Sequencer phases of the scoreboard copy.
  typedef enum logic [1:0] {
    SeqIdle,
    SeqPulseOff,
    SeqPulseOn,
    SeqWait
  } seq_phase_e;

  // One row of the directed table: a register write or an input beat.
  typedef struct {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    in_item_t            beat;
    logic                typed;
    out_item_t           want;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_item_t           out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Scoreboard copy of the configuration and sequencer state.
  cfg_t       cfg_now;
  seq_phase_e seq_phase;
  logic [TicksW-1:0] seq_count;
  logic       key_now;
  logic       want_on_now;

  out_item_t  pending_results[$];
  plan_row_t  plan[$];
  int         mismatches;
  int         beats_sent;
  bit         idle_en;
  bit         rx_hold_req;

  modem_power_key_sequencer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Saturating tick counter of the scoreboard copy.
  function automatic void bump_count();
    if (seq_count != '1) begin
      seq_count++;
    end
  endfunction

  // Advances the scoreboard copy by one beat and returns the result it causes.
  function automatic out_item_t predict_key_seq(in_item_t b);
    out_item_t res;
    logic      is_on;
    logic      hit;
    logic      inactive;
    logic      done;
    logic      ok;
    is_on    = cfg_now.has_status_pin ? (b.status_pin == cfg_now.status_on_level) : 1'b1;
    inactive = ~cfg_now.active_level;
    done     = 1'b0;
    ok       = 1'b0;
    case (seq_phase)
      SeqIdle: begin
        if (b.mode == ModeOn || b.mode == ModeOff) begin
          want_on_now = (b.mode == ModeOn);
          hit = (is_on == want_on_now);
          if (!cfg_now.has_control_pin) begin
            done = 1'b1;
            ok   = 1'b1;
          end else if (cfg_now.held_method) begin
            key_now = want_on_now ? cfg_now.active_level : inactive;
            if (!cfg_now.has_status_pin || hit) begin
              done = 1'b1;
              ok   = 1'b1;
            end else begin
              seq_phase = SeqWait;
              seq_count = '0;
            end
          end else if (cfg_now.has_status_pin && hit) begin
            done = 1'b1;
            ok   = 1'b1;
          end else begin
            key_now   = inactive;
            seq_phase = SeqPulseOff;
            seq_count = '0;
          end
        end
      end
      SeqPulseOff: begin
        if (b.mode == ModeTick) begin
          bump_count();
          if (seq_count >= cfg_now.pulse_ticks) begin
            key_now   = cfg_now.active_level;
            seq_phase = SeqPulseOn;
            seq_count = '0;
          end
        end
      end
      SeqPulseOn: begin
        if (b.mode == ModeTick) begin
          bump_count();
          if (seq_count >= cfg_now.pulse_ticks) begin
            key_now   = inactive;
            seq_count = '0;
            if (!cfg_now.has_status_pin) begin
              seq_phase = SeqIdle;
              done      = 1'b1;
              ok        = 1'b1;
            end else begin
              seq_phase = SeqWait;
            end
          end
        end
      end
      default: begin
        // Every beat samples the status; only ticks move the timeout.
        hit = (is_on == want_on_now);
        if (hit) begin
          seq_phase = SeqIdle;
          done      = 1'b1;
          ok        = 1'b1;
        end else if (b.mode == ModeTick) begin
          bump_count();
          if (seq_count >= cfg_now.timeout_ticks) begin
            seq_phase = SeqIdle;
            done      = 1'b1;
          end
        end
      end
    endcase
    res.key_level = key_now;
    res.busy_res  = (seq_phase != SeqIdle);
    res.done_res  = done;
    res.success   = ok;
    res.modem_on  = is_on;
    return res;
  endfunction

  // Directed table builders.
  function automatic plan_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    plan_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    return row;
  endfunction

  function automatic plan_row_t beat_row(logic [1:0] mode, logic st);
    plan_row_t row;
    row                 = '{default: '0};
    row.beat.mode       = mode;
    row.beat.status_pin = st;
    return row;
  endfunction

  function automatic plan_row_t typed_row(logic [1:0] mode, logic st, out_item_t want);
    plan_row_t row;
    row       = beat_row(mode, st);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_en) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Writes one register and mirrors it into the scoreboard copy.
  task automatic write_cfg_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgHeldMethod:   cfg_now.held_method     = data[0];
      CfgHasControl:   cfg_now.has_control_pin = data[0];
      CfgHasStatus:    cfg_now.has_status_pin  = data[0];
      CfgActiveLevel:  cfg_now.active_level    = data[0];
      CfgStatusOnLvl:  cfg_now.status_on_level = data[0];
      CfgPulseTicks:   cfg_now.pulse_ticks     = data[TicksW-1:0];
      CfgTimeoutTicks: cfg_now.timeout_ticks   = data[TicksW-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offers one beat until it is taken, then records its expected result.
  task automatic send_beat(in_item_t b, logic typed, out_item_t want);
    out_item_t guess;
    int        gap;
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    guess = predict_key_seq(b);
    pending_results.push_back(typed ? want : guess);
    beats_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops offering and waits until every expected result has come out.
  task automatic idle_block();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      $error("result beat with no expectation: %b", got);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (got.key_level !== want.key_level) begin
      $error("key_level: expected %0b, got %0b", want.key_level, got.key_level);
      mismatches++;
    end
    if (got.busy_res !== want.busy_res) begin
      $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
      mismatches++;
    end
    if (got.done_res !== want.done_res) begin
      $error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
      mismatches++;
    end
    if (got.success !== want.success) begin
      $error("success: expected %0b, got %0b", want.success, got.success);
      mismatches++;
    end
    if (got.modem_on !== want.modem_on) begin
      $error("modem_on: expected %0b, got %0b", want.modem_on, got.modem_on);
      mismatches++;
    end
  endtask

  // Result side: checks each beat and stalls at random, once for a long stretch.
  initial begin
    int stall_left;
    int r;
    out_ready_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        check_result(out_data_o);
      end
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall_left  = LongHold;
      end else if (stall_left == 0 && idle_en && rst_ni) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          stall_left = $urandom_range(1, 3);
        end else if (r < 14) begin
          stall_left = $urandom_range(15, 50);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= rst_ni;
      end
    end
  end

  // Ends the run when no beat moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("modem_power_key_sequencer_top: mismatch");
    $finish;
  end

  // Stimulus: directed table first, then random phases of request sequences.
  initial begin
    in_item_t   b;
    logic       want;
    logic       st;
    logic       target_st;
    int         len;
    int         flip_at;
    int         start;
    int         r;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    mismatches  = 0;
    beats_sent  = 0;
    idle_en     = 1'b1;
    rx_hold_req = 1'b0;

    cfg_now               = '0;
    cfg_now.timeout_ticks = DefaultTimeout;
    seq_phase             = SeqIdle;
    seq_count             = '0;
    key_now               = 1'b1;
    want_on_now           = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state: no control pin, so a request succeeds at once.
    plan.push_back(typed_row(ModeTick, 1'b0, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1}));
    plan.push_back(typed_row(ModeOn, 1'b0, '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1}));
    plan.push_back(typed_row(ModeSpare, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1}));
    // Pulsed method with zero pulse and zero timeout.
    plan.push_back(cfg_row(CfgHasControl, 16'd1));
    plan.push_back(cfg_row(CfgHasStatus, 16'd1));
    plan.push_back(cfg_row(CfgActiveLevel, 16'd1));
    plan.push_back(cfg_row(CfgStatusOnLvl, 16'd1));
    plan.push_back(cfg_row(CfgPulseTicks, 16'd0));
    plan.push_back(cfg_row(CfgTimeoutTicks, 16'd0));
    plan.push_back(typed_row(ModeOn, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1}));
    plan.push_back(beat_row(ModeOff, 1'b1));
    plan.push_back(beat_row(ModeTick, 1'b1));
    plan.push_back(beat_row(ModeOn, 1'b1));
    plan.push_back(beat_row(ModeTick, 1'b1));
    plan.push_back(typed_row(ModeTick, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1}));
    // Held method: already on, then a wait ended by a non-tick beat.
    plan.push_back(cfg_row(CfgHeldMethod, 16'd1));
    plan.push_back(typed_row(ModeOn, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1}));
    plan.push_back(beat_row(ModeOff, 1'b1));
    plan.push_back(beat_row(ModeOff, 1'b0));
    // Held method without a status pin, with the widest counts.
    plan.push_back(cfg_row(CfgHasStatus, 16'd0));
    plan.push_back(cfg_row(CfgPulseTicks, 16'hFFFF));
    plan.push_back(cfg_row(CfgTimeoutTicks, 16'hFFFF));
    plan.push_back(typed_row(ModeOn, 1'b0, '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1}));
    // Pulsed method without a status pin.
    plan.push_back(cfg_row(CfgHeldMethod, 16'd0));
    plan.push_back(cfg_row(CfgPulseTicks, 16'd2));
    plan.push_back(beat_row(ModeOff, 1'b1));
    plan.push_back(beat_row(ModeTick, 1'b1));
    plan.push_back(beat_row(ModeTick, 1'b0));
    plan.push_back(beat_row(ModeSpare, 1'b0));
    plan.push_back(beat_row(ModeTick, 1'b1));
    plan.push_back(beat_row(ModeTick, 1'b0));
    // Low active level and low on level, ending in a timeout.
    plan.push_back(cfg_row(CfgHasStatus, 16'd1));
    plan.push_back(cfg_row(CfgStatusOnLvl, 16'd0));
    plan.push_back(cfg_row(CfgActiveLevel, 16'd0));
    plan.push_back(cfg_row(CfgTimeoutTicks, 16'd3));
    plan.push_back(beat_row(ModeOn, 1'b1));
    plan.push_back(beat_row(ModeTick, 1'b1));
    plan.push_back(beat_row(ModeTick, 1'b1));
    plan.push_back(beat_row(ModeTick, 1'b1));
    plan.push_back(beat_row(ModeTick, 1'b1));
    plan.push_back(beat_row(ModeTick, 1'b1));
    plan.push_back(beat_row(ModeSpare, 1'b1));
    plan.push_back(beat_row(ModeTick, 1'b1));
    plan.push_back(beat_row(ModeTick, 1'b1));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        idle_block();
        write_cfg_reg(plan[i].idx, plan[i].data);
      end else begin
        send_beat(plan[i].beat, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      idle_block();
      idle_en = (ph % 3 != 1);
      write_cfg_reg(CfgHeldMethod, 16'($urandom_range(0, 1)));
      write_cfg_reg(CfgHasControl, 16'($urandom_range(0, 7) != 0));
      write_cfg_reg(CfgHasStatus, 16'($urandom_range(0, 5) != 0));
      write_cfg_reg(CfgActiveLevel, 16'($urandom_range(0, 1)));
      write_cfg_reg(CfgStatusOnLvl, 16'($urandom_range(0, 1)));
      r = $urandom_range(0, 19);
      write_cfg_reg(CfgPulseTicks, (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
                    16'($urandom_range(1, 6)));
      r = $urandom_range(0, 19);
      write_cfg_reg(CfgTimeoutTicks, (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
                    16'($urandom_range(1, 15)));
      // The result side holds off while beats keep coming without gaps.
      if (ph == 4) begin
        rx_hold_req = 1'b1;
      end
      start = beats_sent;
      while (beats_sent - start < PhaseBeats) begin
        if ($urandom_range(0, 9) < 8) begin
          // A request followed by mostly ticks, the status may turn to the target level at some point.
          want      = 1'($urandom_range(0, 1));
          target_st = want ? cfg_now.status_on_level : ~cfg_now.status_on_level;
          st        = 1'($urandom_range(0, 1));
          b.mode       = want ? ModeOn : ModeOff;
          b.status_pin = st;
          send_beat(b, 1'b0, '0);
          len     = $urandom_range(2, 30);
          flip_at = $urandom_range(0, len + 8);
          for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 19);
            if (r < 16) begin
              b.mode = ModeTick;
            end else if (r < 18) begin
              b.mode = $urandom_range(0, 1) ? ModeOn : ModeOff;
            end else begin
              b.mode = ModeSpare;
            end
            if (k >= flip_at) begin
              b.status_pin = target_st;
            end else begin
              b.status_pin = ($urandom_range(0, 9) < 8) ? st : ~st;
            end
            send_beat(b, 1'b0, '0);
          end
        end else begin
          // Noise: any mode, any status.
          repeat ($urandom_range(1, 4)) begin
            b.mode       = 2'($urandom_range(0, 3));
            b.status_pin = 1'($urandom_range(0, 1));
            send_beat(b, 1'b0, '0);
          end
        end
      end
    end

    idle_block();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("modem_power_key_sequencer_top: match");
    end else begin
      $display("modem_power_key_sequencer_top: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
src/pks_pkg.sv
src/pks_cfg_regs.sv
src/pks_core.sv
src/modem_power_key_sequencer_top.sv
dv/modem_power_key_sequencer_top_tb.sv
